// ----- rtl/core/acia_pkg.sv -----
// shared types, codes and helper functions for the acia serial interface
`default_nettype none

package acia_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_RD_STAT  = 3'd1,
    ACT_RD_DATA  = 3'd2,
    ACT_WR_CTRL  = 3'd3,
    ACT_WR_DATA  = 3'd4
  } acia_action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DCD_WIRED   = 2'd0,
    REG_CTS_WIRED   = 2'd1,
    REG_TICKS_SHORT = 2'd2,
    REG_TICKS_LONG  = 2'd3
  } acia_reg_t;

  localparam int CntW = 24;

  // control register fields
  localparam logic [1:0] DIV_MASTER_RESET = 2'b11;
  localparam logic [1:0] TXCTL_TX_IRQ     = 2'b01;
  localparam logic [1:0] TXCTL_RTS_OFF    = 2'b10;
  localparam logic [1:0] TXCTL_BREAK      = 2'b11;

  // bit n set: word format n uses an 11-bit frame
  localparam logic [7:0] LONG_FRAME_MAP = 8'b1101_0011;

  typedef struct packed {
    logic            dcd_wired;
    logic            cts_wired;
    logic [CntW-1:0] ticks_short_frame;
    logic [CntW-1:0] ticks_long_frame;
  } acia_cfg_t;

  typedef struct packed {
    logic [7:0]      control_reg;
    logic [7:0]      receive_byte;
    logic            receive_full;
    logic            carrier_flag;
    logic            carrier_irq;
    logic            flag_follows_pin;
    logic            status_was_read;
    logic            carrier_lost_sample;
    logic            cts_sample;
    logic            room_sample;
    logic [CntW-1:0] tx_busy_count;
    logic [CntW-1:0] rx_wait_count;
  } acia_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_in;
    logic       carrier_in;
    logic       cts_in;
    logic       sink_room;
    logic       source_ready;
    logic [7:0] source_byte;
  } acia_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       source_take;
    logic       rts_out;
    logic       break_out;
    logic       irq_out;
    logic [2:0] word_format;
  } acia_result_t;

  function automatic logic tdre_f(acia_state_t s);
    return (s.control_reg[1:0] != DIV_MASTER_RESET) && (s.tx_busy_count == '0) &&
           s.cts_sample && s.room_sample;
  endfunction

  function automatic logic irq_f(acia_state_t s);
    return (s.control_reg[7] && (s.receive_full || s.carrier_irq)) ||
           ((s.control_reg[6:5] == TXCTL_TX_IRQ) && tdre_f(s));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/acia_step.sv -----
// next-state and result logic for one acia transaction
`default_nettype none

module acia_step (
  input  acia_pkg::acia_cfg_t    cfg,
  input  acia_pkg::acia_state_t  st,
  input  acia_pkg::acia_item_t   item,
  output acia_pkg::acia_state_t  st_next,
  output acia_pkg::acia_result_t res
);
  import acia_pkg::*;

  logic                lost;
  logic                cts_now;
  logic                in_rst;
  logic [CntW-1:0]     frame;
  logic                take;
  acia_state_t         smp;
  acia_state_t         nx;
  logic [7:0]          rv;
  logic [7:0]          new_ctrl;

  assign lost     = cfg.dcd_wired & ~item.carrier_in;
  assign cts_now  = cfg.cts_wired ? item.cts_in : 1'b1;
  assign in_rst   = (st.control_reg[1:0] == DIV_MASTER_RESET);
  assign frame    = LONG_FRAME_MAP[st.control_reg[4:2]] ? cfg.ticks_long_frame
                                                         : cfg.ticks_short_frame;
  assign new_ctrl = item.data_in;

  // pin sampling and receive path, shared by tick and reads
  always_comb begin
    smp  = st;
    take = 1'b0;
    if (acia_action_t'(item.action) == ACT_TICK) begin
      if (st.tx_busy_count != '0) smp.tx_busy_count = st.tx_busy_count - 1'b1;
      if (st.rx_wait_count != '0) smp.rx_wait_count = st.rx_wait_count - 1'b1;
    end
    smp.cts_sample  = cts_now;
    smp.room_sample = item.sink_room;
    if (lost && !st.carrier_lost_sample) begin
      smp.carrier_flag     = 1'b1;
      smp.carrier_irq      = 1'b1;
      smp.flag_follows_pin = 1'b0;
      smp.status_was_read  = 1'b0;
      smp.receive_full     = 1'b0;
    end
    smp.carrier_lost_sample = lost;
    if (smp.flag_follows_pin) smp.carrier_flag = lost;
    if (!lost && !in_rst && !smp.receive_full && (smp.rx_wait_count == '0) &&
        item.source_ready) begin
      take              = 1'b1;
      smp.receive_byte  = item.source_byte;
      smp.receive_full  = 1'b1;
      smp.rx_wait_count = frame;
    end
  end

  always_comb begin
    nx  = st;
    rv  = '0;
    res = '0;
    case (acia_action_t'(item.action))
      ACT_TICK: begin
        nx = smp;
      end
      ACT_RD_STAT: begin
        nx = smp;
        rv = {irq_f(smp), 3'b000, ~smp.cts_sample, smp.carrier_flag, tdre_f(smp),
              smp.receive_full};
        if (smp.carrier_flag) nx.status_was_read = 1'b1;
      end
      ACT_RD_DATA: begin
        nx = smp;
        nx.receive_full = 1'b0;
        if (smp.status_was_read && smp.carrier_flag) begin
          nx.carrier_irq      = 1'b0;
          nx.status_was_read  = 1'b0;
          nx.flag_follows_pin = 1'b1;
          nx.carrier_flag     = smp.carrier_lost_sample;
        end
        rv = smp.receive_byte;
      end
      ACT_WR_CTRL: begin
        nx.control_reg = new_ctrl;
        if (new_ctrl[1:0] == DIV_MASTER_RESET) begin
          nx.receive_full        = 1'b0;
          nx.receive_byte        = '0;
          nx.tx_busy_count       = '0;
          nx.rx_wait_count       = '0;
          nx.carrier_irq         = 1'b0;
          nx.status_was_read     = 1'b0;
          nx.flag_follows_pin    = 1'b1;
          nx.carrier_lost_sample = lost;
          nx.carrier_flag        = lost;
          nx.cts_sample          = cts_now;
          nx.room_sample         = item.sink_room;
        end
      end
      ACT_WR_DATA: begin
        nx.tx_busy_count = frame;
        res.tx_valid     = 1'b1;
        res.tx_byte      = item.data_in;
      end
      default: begin
        nx = st;
      end
    endcase
    res.read_value  = rv;
    res.source_take = take && ((acia_action_t'(item.action) == ACT_TICK) ||
                               (acia_action_t'(item.action) == ACT_RD_STAT) ||
                               (acia_action_t'(item.action) == ACT_RD_DATA));
    res.rts_out     = (nx.control_reg[6:5] != TXCTL_RTS_OFF);
    res.break_out   = (nx.control_reg[6:5] == TXCTL_BREAK);
    res.irq_out     = irq_f(nx);
    res.word_format = nx.control_reg[4:2];
  end

  assign st_next = nx;

endmodule

`default_nettype wire

// ----- rtl/core/acia_serial_interface_top.sv -----
// top level of the acia serial interface: stream ports, apb registers, state and output skid
`default_nettype none

// Register-level ACIA model driven by a stream of transactions. Each input
// transaction is one action (tuser: tick, status read, data read, control write,
// data write) along with the line pins it samples; each produces exactly one
// result transaction carrying the read value, the transmitted byte, the receive
// take flag and the modem/irq pin states after the action. One transaction is
// accepted every clock cycle unless the skid register is full; its result is
// registered. The whole update is one pass of flag logic and a 24-bit decrement and
// select between the state registers and the result register. A two-entry output
// (result register plus skid register) keeps input accepted while one result waits
// on a stalled output. Frame timing registers and pin wiring are set over the apb
// port, which should be written only while the block is idle.
module acia_serial_interface_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // stream input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // data_in[7:0], carrier_in[8], cts_in[9], sink_room[10], source_ready[11],
  // source_byte[19:12], zero pad [23:20]
  input  wire logic [23:0] s_tdata,
  // action[2:0]
  input  wire logic [2:0]  s_tuser,
  // stream output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // read_value[7:0], tx_valid[8], tx_byte[16:9], source_take[17], rts_out[18],
  // break_out[19], irq_out[20], word_format[23:21]
  output logic [23:0]      m_tdata,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import acia_pkg::*;

  acia_cfg_t    cfg;
  acia_state_t  st;
  acia_state_t  st_next;
  acia_item_t   item;
  acia_result_t res;
  logic [23:0]  res_data;
  logic [23:0]  skid_data;
  logic         skid_valid;
  logic         in_accept;
  logic         out_free;
  logic         cfg_wr;
  acia_reg_t    reg_sel;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = acia_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dcd_wired         <= 1'b0;
      cfg.cts_wired         <= 1'b0;
      cfg.ticks_short_frame <= CntW'(2083);
      cfg.ticks_long_frame  <= CntW'(2291);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DCD_WIRED:   cfg.dcd_wired         <= pwdata[0];
        REG_CTS_WIRED:   cfg.cts_wired         <= pwdata[0];
        REG_TICKS_SHORT: cfg.ticks_short_frame <= pwdata[CntW-1:0];
        REG_TICKS_LONG:  cfg.ticks_long_frame  <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DCD_WIRED:   prdata = {31'd0, cfg.dcd_wired};
      REG_CTS_WIRED:   prdata = {31'd0, cfg.cts_wired};
      REG_TICKS_SHORT: prdata = {8'd0, cfg.ticks_short_frame};
      REG_TICKS_LONG:  prdata = {8'd0, cfg.ticks_long_frame};
      default:         prdata = '0;
    endcase
  end

  // ---------------- input unpack ----------------
  assign item.action       = s_tuser;
  assign item.data_in      = s_tdata[7:0];
  assign item.carrier_in   = s_tdata[8];
  assign item.cts_in       = s_tdata[9];
  assign item.sink_room    = s_tdata[10];
  assign item.source_ready = s_tdata[11];
  assign item.source_byte  = s_tdata[19:12];

  // input is held off only when both output slots are occupied
  assign s_tready  = ~skid_valid;
  assign in_accept = s_tvalid & s_tready;

  // ---------------- state update ----------------
  acia_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.control_reg         <= '0;
      st.receive_byte        <= '0;
      st.receive_full        <= 1'b0;
      st.carrier_flag        <= 1'b0;
      st.carrier_irq         <= 1'b0;
      st.flag_follows_pin    <= 1'b1;
      st.status_was_read     <= 1'b0;
      st.carrier_lost_sample <= 1'b0;
      st.cts_sample          <= 1'b1;
      st.room_sample         <= 1'b1;
      st.tx_busy_count       <= '0;
      st.rx_wait_count       <= '0;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  // ---------------- result register and skid ----------------
  assign res_data = {res.word_format, res.irq_out, res.break_out, res.rts_out,
                     res.source_take, res.tx_byte, res.tx_valid, res.read_value};
  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // skid drains first; skid_valid blocks new input so the two never collide
      m_tvalid   <= skid_valid | in_accept;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_valid ? skid_data : res_data;
    end else if (in_accept) begin
      skid_data <= res_data;
    end
  end

  // ---------------- assertions ----------------
  // a held skid entry means the result register is also occupied
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry without result register");

  // an accepted transaction always leaves a result pending next cycle
  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_tvalid)
    else $error("accepted transaction produced no result");

  // a pending carrier interrupt keeps the carrier flag latched
  a_carrier_latch: assert property (@(posedge clk) disable iff (rst)
    st.carrier_irq |-> (st.carrier_flag && !st.flag_follows_pin))
    else $error("carrier interrupt without latched flag");

  // master reset keeps the receiver empty and unpaced
  a_reset_rx_idle: assert property (@(posedge clk) disable iff (rst)
    (st.control_reg[1:0] == DIV_MASTER_RESET) |->
      (!st.receive_full && (st.rx_wait_count == '0)))
    else $error("receiver active during master reset");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the acia serial interface: stream actions, apb setup, result checks

module testbench;
  import acia_pkg::*;

  // status byte bit positions
  localparam int STAT_RDRF = 0;
  localparam int STAT_TDRE = 1;
  localparam int STAT_DCD  = 2;
  localparam int STAT_CTS  = 3;
  localparam int STAT_IRQ  = 7;

  // highest code that fits the action field; codes above write data are unused
  localparam logic [2:0] ACT_LAST_CODE = 3'd7;

  // quiet cycles before the run is declared hung, and settle time after the last result
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  // one input transaction as the line and the bus present it
  typedef struct packed {
    logic [2:0] act;
    logic [7:0] wr_byte;
    logic       dcd_pin;
    logic       cts_pin;
    logic       room_pin;
    logic       rx_avail;
    logic [7:0] rx_in;
  } stim_t;

  // one result transaction, unpacked from m_tdata
  typedef struct packed {
    logic [7:0] read_val;
    logic       tx_strobe;
    logic [7:0] tx_data;
    logic       rx_take;
    logic       rts;
    logic       brk;
    logic       irq;
    logic [2:0] wfmt;
  } acia_out_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // 10 time unit clock
  always #5 clk = ~clk;

  acia_serial_interface_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // predictor: mirror of the line setup and of the chip registers
  // ---------------------------------------------------------------------------

  // line setup as written over apb
  logic            cfg_dcd_live;
  logic            cfg_cts_live;
  logic [CntW-1:0] cfg_short_ticks;
  logic [CntW-1:0] cfg_long_ticks;

  // chip state
  logic [7:0]      ctl_reg;
  logic [7:0]      rx_data;
  logic            rx_full;
  logic            dcd_flag;         // carrier-lost status bit
  logic            dcd_irq;          // latched carrier-loss interrupt
  logic            dcd_tracks_pin;   // flag follows the pin unless latched
  logic            dcd_status_seen;  // status was read while the flag was up
  logic            dcd_lost_prev;    // carrier-lost level at the last sample
  logic            cts_seen;
  logic            room_seen;
  logic [CntW-1:0] tx_busy_left;
  logic [CntW-1:0] rx_pace_left;

  // results still owed by the block, oldest first
  acia_out_t expected_outputs[$];

  int bad_results;
  int quiet_cycles;
  int src_idle_lvl;   // 0 none, 1 light, 2 heavy
  int snk_idle_lvl;

  function automatic void chip_power_on();
    cfg_dcd_live    = 1'b0;
    cfg_cts_live    = 1'b0;
    cfg_short_ticks = 24'd2083;
    cfg_long_ticks  = 24'd2291;
    ctl_reg         = '0;
    rx_data         = '0;
    rx_full         = 1'b0;
    dcd_flag        = 1'b0;
    dcd_irq         = 1'b0;
    dcd_tracks_pin  = 1'b1;
    dcd_status_seen = 1'b0;
    dcd_lost_prev   = 1'b0;
    cts_seen        = 1'b1;
    room_seen       = 1'b1;
    tx_busy_left    = '0;
    rx_pace_left    = '0;
  endfunction

  function automatic logic carrier_gone(stim_t s);
    return cfg_dcd_live && !s.dcd_pin;
  endfunction

  function automatic logic clear_to_send(stim_t s);
    return !cfg_cts_live || s.cts_pin;
  endfunction

  function automatic logic chip_held();
    return ctl_reg[1:0] == DIV_MASTER_RESET;
  endfunction

  // ticks of one character at the current word format
  function automatic logic [CntW-1:0] char_ticks();
    return LONG_FRAME_MAP[ctl_reg[4:2]] ? cfg_long_ticks : cfg_short_ticks;
  endfunction

  function automatic logic tx_empty();
    return !chip_held() && (tx_busy_left == '0) && cts_seen && room_seen;
  endfunction

  function automatic logic irq_level();
    return (ctl_reg[7] && (rx_full || dcd_irq)) ||
           ((ctl_reg[6:5] == TXCTL_TX_IRQ) && tx_empty());
  endfunction

  // pin sampling shared by ticks and reads; returns 1 when a byte is taken in
  function automatic logic sample_line(stim_t s);
    logic lost;
    lost      = carrier_gone(s);
    cts_seen  = clear_to_send(s);
    room_seen = s.room_pin;
    // falling carrier latches the flag and drops the receiver
    if (lost && !dcd_lost_prev) begin
      dcd_flag        = 1'b1;
      dcd_irq         = 1'b1;
      dcd_tracks_pin  = 1'b0;
      dcd_status_seen = 1'b0;
      rx_full         = 1'b0;
    end
    dcd_lost_prev = lost;
    if (dcd_tracks_pin) dcd_flag = lost;
    if (lost || chip_held() || rx_full || (rx_pace_left != '0) || !s.rx_avail) return 1'b0;
    rx_data      = s.rx_in;
    rx_full      = 1'b1;
    rx_pace_left = char_ticks();
    return 1'b1;
  endfunction

  function automatic acia_out_t predict_action(stim_t s);
    acia_out_t r;
    r = '0;
    case (s.act)
      ACT_TICK: begin
        if (tx_busy_left != '0) tx_busy_left = tx_busy_left - 1'b1;
        if (rx_pace_left != '0) rx_pace_left = rx_pace_left - 1'b1;
        r.rx_take = sample_line(s);
      end
      ACT_RD_STAT: begin
        r.rx_take             = sample_line(s);
        r.read_val[STAT_RDRF] = rx_full;
        r.read_val[STAT_TDRE] = tx_empty();
        r.read_val[STAT_DCD]  = dcd_flag;
        r.read_val[STAT_CTS]  = !cts_seen;
        r.read_val[STAT_IRQ]  = irq_level();
        if (dcd_flag) dcd_status_seen = 1'b1;
      end
      ACT_RD_DATA: begin
        r.rx_take = sample_line(s);
        rx_full   = 1'b0;
        // status then data read releases the carrier latch
        if (dcd_status_seen && dcd_flag) begin
          dcd_irq         = 1'b0;
          dcd_status_seen = 1'b0;
          dcd_tracks_pin  = 1'b1;
          dcd_flag        = dcd_lost_prev;
        end
        r.read_val = rx_data;
      end
      ACT_WR_CTRL: begin
        ctl_reg = s.wr_byte;
        if (chip_held()) begin
          rx_full         = 1'b0;
          rx_data         = '0;
          tx_busy_left    = '0;
          rx_pace_left    = '0;
          dcd_irq         = 1'b0;
          dcd_status_seen = 1'b0;
          dcd_tracks_pin  = 1'b1;
          dcd_lost_prev   = carrier_gone(s);
          dcd_flag        = dcd_lost_prev;
          cts_seen        = clear_to_send(s);
          room_seen       = s.room_pin;
        end
      end
      ACT_WR_DATA: begin
        r.tx_strobe  = 1'b1;
        r.tx_data    = s.wr_byte;
        tx_busy_left = char_ticks();
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
    r.rts  = ctl_reg[6:5] != TXCTL_RTS_OFF;
    r.brk  = ctl_reg[6:5] == TXCTL_BREAK;
    r.irq  = irq_level();
    r.wfmt = ctl_reg[4:2];
    return r;
  endfunction

  function automatic string out_str(acia_out_t r);
    return $sformatf("rd=%02h txv=%0b txb=%02h take=%0b rts=%0b brk=%0b irq=%0b fmt=%0d",
                     r.read_val, r.tx_strobe, r.tx_data, r.rx_take, r.rts, r.brk, r.irq,
                     r.wfmt);
  endfunction

  // ---------------------------------------------------------------------------
  // idle patterns: mostly short gaps, a few long ones
  // ---------------------------------------------------------------------------

  function automatic int pick_gap(int level);
    int r;
    r = $urandom_range(0, 99);
    case (level)
      0: return 0;
      1: begin
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
      end
      default: begin
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
    endcase
  endfunction

  // never returns zero, so ready never drops and rises in one step
  function automatic int pick_stall(int level);
    int r;
    r = $urandom_range(0, 99);
    if (level == 1) begin
      if (r < 85) return $urandom_range(1, 2);
      return $urandom_range(5, 12);
    end
    if (r < 80) return $urandom_range(1, 4);
    return $urandom_range(10, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_t mk_stim(logic [2:0] act, logic [7:0] wr_byte, logic dcd_pin,
                                    logic cts_pin, logic room_pin, logic rx_avail,
                                    logic [7:0] rx_in);
    stim_t s;
    s.act      = act;
    s.wr_byte  = wr_byte;
    s.dcd_pin  = dcd_pin;
    s.cts_pin  = cts_pin;
    s.room_pin = room_pin;
    s.rx_avail = rx_avail;
    s.rx_in    = rx_in;
    return s;
  endfunction

  // random action with pins that are mostly good, so the chip gets past its
  // early states; master reset on about one control write in five
  function automatic stim_t rand_stim();
    stim_t s;
    int    r;
    r          = $urandom_range(0, 99);
    s.wr_byte  = 8'($urandom);
    s.dcd_pin  = $urandom_range(0, 19) != 0;
    s.cts_pin  = $urandom_range(0, 9) != 0;
    s.room_pin = $urandom_range(0, 7) != 0;
    s.rx_avail = 1'($urandom_range(0, 1));
    s.rx_in    = 8'($urandom);
    if (r < 38) s.act = ACT_TICK;
    else if (r < 58) s.act = ACT_RD_STAT;
    else if (r < 73) s.act = ACT_RD_DATA;
    else if (r < 81) s.act = ACT_WR_CTRL;
    else if (r < 95) s.act = ACT_WR_DATA;
    else s.act = 3'($urandom_range(int'(ACT_WR_DATA) + 1, int'(ACT_LAST_CODE)));
    if (s.act == ACT_WR_CTRL) begin
      if ($urandom_range(0, 4) == 0) s.wr_byte[1:0] = DIV_MASTER_RESET;
      else if (s.wr_byte[1:0] == DIV_MASTER_RESET) s.wr_byte[1:0] = 2'($urandom_range(0, 2));
    end
    return s;
  endfunction

  // one input transaction; valid stays up when the next one follows at once
  task automatic send_stim(stim_t st);
    int gap;
    gap = pick_gap(src_idle_lvl);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, st.rx_in, st.rx_avail, st.room_pin, st.cts_pin, st.dcd_pin,
                 st.wr_byte};
    s_tuser  <= st.act;
    do @(posedge clk); while (!s_tready);
    // accepted at this edge
    expected_outputs.insert(expected_outputs.size(), predict_action(st));
  endtask

  // stop sending and let every owed result come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic reg_write(acia_reg_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DCD_WIRED:   cfg_dcd_live    = val[0];
      REG_CTS_WIRED:   cfg_cts_live    = val[0];
      REG_TICKS_SHORT: cfg_short_ticks = val[CntW-1:0];
      REG_TICKS_LONG:  cfg_long_ticks  = val[CntW-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_line_setup(logic dcd_live, logic cts_live, logic [CntW-1:0] short_t,
                                logic [CntW-1:0] long_t);
    wait_idle();
    reg_write(REG_DCD_WIRED, {31'd0, dcd_live});
    reg_write(REG_CTS_WIRED, {31'd0, cts_live});
    reg_write(REG_TICKS_SHORT, {8'd0, short_t});
    reg_write(REG_TICKS_LONG, {8'd0, long_t});
  endtask

  // random traffic; with the carrier pin wired, recovery_pct of the picks are a carrier
  // drop followed by the status read and data read that release the latch
  task automatic run_random_mix(int n, int recovery_pct);
    stim_t st;
    int    sent;
    int    extra;
    sent = 0;
    while (sent < n) begin
      if (cfg_dcd_live && ($urandom_range(0, 99) < recovery_pct)) begin
        st = rand_stim();
        st.act = ACT_TICK;
        st.dcd_pin = 1'b0;
        send_stim(st);
        extra = $urandom_range(0, 2);
        repeat (extra) begin
          st = rand_stim();
          st.act = ACT_TICK;
          send_stim(st);
        end
        st = rand_stim();
        st.act = ACT_RD_STAT;
        st.dcd_pin = 1'b1;
        send_stim(st);
        st = rand_stim();
        st.act = ACT_RD_DATA;
        st.dcd_pin = 1'b1;
        send_stim(st);
        sent += 3 + extra;
      end else begin
        st = rand_stim();
        send_stim(st);
        if (st.act <= ACT_WR_DATA) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // power-on setup: pins tied, long pacing counts
  task automatic test_power_on_defaults();
    src_idle_lvl = 0;
    snk_idle_lvl = 0;
    send_stim(mk_stim(ACT_RD_STAT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_WR_DATA, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_TICK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 8'h3C));
    send_stim(mk_stim(ACT_RD_STAT, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 8'h77));
    send_stim(mk_stim(ACT_RD_DATA, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 8'h77));
    // receive pacing still running: no take
    send_stim(mk_stim(ACT_TICK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 8'h55));
  endtask

  task automatic test_directed_cases();
    src_idle_lvl = 1;
    snk_idle_lvl = 1;
    set_line_setup(1'b1, 1'b1, 24'd2, 24'd3);
    // master reset, then receive irq enabled with a short frame format
    send_stim(mk_stim(ACT_WR_CTRL, 8'h03, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_WR_CTRL, 8'h94, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_TICK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
    send_stim(mk_stim(ACT_RD_STAT, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_RD_DATA, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    // data read with the receiver already empty
    send_stim(mk_stim(ACT_RD_DATA, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    // transmit irq, long frame; second write lands while busy
    send_stim(mk_stim(ACT_WR_CTRL, 8'h3D, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_WR_DATA, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_WR_DATA, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    repeat (3) send_stim(mk_stim(ACT_TICK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    // clear to send negated and sink full
    send_stim(mk_stim(ACT_RD_STAT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_WR_CTRL, 8'h40, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_WR_CTRL, 8'hE0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    // carrier loss latches, then status read and data read release it
    send_stim(mk_stim(ACT_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'h12));
    send_stim(mk_stim(ACT_RD_STAT, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    send_stim(mk_stim(ACT_RD_DATA, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
    // unused action codes with every field at an extreme
    for (int a = int'(ACT_WR_DATA) + 1; a <= int'(ACT_LAST_CODE); a++) begin
      if (a[0]) send_stim(mk_stim(3'(a), 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
      else send_stim(mk_stim(3'(a), 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    end
  endtask

  task automatic test_tied_pins();
    set_line_setup(1'b0, 1'b0, 24'd3, 24'd5);
    src_idle_lvl = 1;
    snk_idle_lvl = 1;
    run_random_mix(255, 5);
  endtask

  task automatic test_zero_pacing();
    set_line_setup(1'b1, 1'b1, 24'd0, 24'd0);
    src_idle_lvl = 0;
    snk_idle_lvl = 0;
    run_random_mix(255, 10);
  endtask

  task automatic test_heavy_stalls();
    set_line_setup(1'b1, 1'b1, 24'd1, 24'd2);
    src_idle_lvl = 2;
    snk_idle_lvl = 2;
    run_random_mix(255, 10);
  endtask

  // short frames never finish; only master reset frees the counters
  task automatic test_max_short_frame();
    set_line_setup(1'b1, 1'b0, 24'hFF_FFFF, 24'd7);
    src_idle_lvl = 1;
    snk_idle_lvl = 0;
    run_random_mix(255, 10);
  endtask

  task automatic test_max_long_frame();
    set_line_setup(1'b0, 1'b1, 24'd12, 24'hFF_FFFF);
    src_idle_lvl = 0;
    snk_idle_lvl = 1;
    run_random_mix(255, 5);
  endtask

  task automatic test_carrier_recovery();
    set_line_setup(1'b1, 1'b1, 24'd4, 24'd6);
    src_idle_lvl = 1;
    snk_idle_lvl = 1;
    run_random_mix(255, 40);
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready pattern, checker, watchdog
  // ---------------------------------------------------------------------------

  initial begin : result_ready
    int hold;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (snk_idle_lvl == 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        hold = $urandom_range(1, 10);
        repeat (hold) @(posedge clk);
        m_tready <= 1'b0;
        hold = pick_stall(snk_idle_lvl);
        repeat (hold) @(posedge clk);
      end
    end
  end

  // every accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    acia_out_t got;
    acia_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.read_val  = m_tdata[7:0];
      got.tx_strobe = m_tdata[8];
      got.tx_data   = m_tdata[16:9];
      got.rx_take   = m_tdata[17];
      got.rts       = m_tdata[18];
      got.brk       = m_tdata[19];
      got.irq       = m_tdata[20];
      got.wfmt      = m_tdata[23:21];
      if (expected_outputs.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected result: %s", out_str(got));
      end else begin
        want = expected_outputs.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch %0d at %0t", bad_results, $time);
            $display("  expected %s", out_str(want));
            $display("  actual   %s", out_str(got));
          end
        end
      end
    end
  end

  // hang detection: no transaction on either side and no register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    bad_results  = 0;
    quiet_cycles = 0;
    src_idle_lvl = 0;
    snk_idle_lvl = 0;
    chip_power_on();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_power_on_defaults();
    test_directed_cases();
    test_tied_pins();
    test_zero_pacing();
    test_heavy_stalls();
    test_max_short_frame();
    test_max_long_frame();
    test_carrier_recovery();

    wait_idle();
    if (bad_results == 0 && expected_outputs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
